[src/cep_pkg.sv]
// cep_pkg: shared types, codes and constants of the crowding effect block
// used by the channel interfaces, the log2 and exp2 pipelines and the top level
// no dependencies
package cep_pkg;

  localparam int NUM_SPECIES_DEF = 64;

  localparam int SPECIES_W = 6;
  localparam int SEL_W     = 2;
  localparam int COEF_W    = 24;
  localparam int DIAM_W    = 24;
  localparam int NCI_W     = 32;
  localparam int RES_W     = 17;

  localparam int LOG_STEPS = 16;
  localparam int EXP_STEPS = 16;

  localparam logic OP_CALC  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [SEL_W-1:0] SEL_SLOPE = 2'd0;
  localparam logic [SEL_W-1:0] SEL_STEEP = 2'd1;
  localparam logic [SEL_W-1:0] SEL_GAMMA = 2'd2;

  localparam logic [RES_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [31:0]      ONE_Q30   = 32'h4000_0000;
  localparam logic [30:0]      LOG2E_Q30 = 31'd1549082005;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             sat;
  } res_t;

  // everything that rides along the pipeline next to the valid bit
  typedef struct packed {
    logic                     in_range;
    logic [DIAM_W-1:0]        diam;
    logic [NCI_W-1:0]         nci;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] g;
    logic                     diam_zero;
    logic                     nci_zero;
    logic signed [45:0]       pd;
    logic signed [45:0]       pg;
    logic                     calc;
    logic [RES_W-1:0]         res;
    logic                     sat;
    logic signed [15:0]       ip;
    logic [15:0]              fp;
    logic [24:0]              t;
    logic [55:0]              z;
    logic [20:0]              a;
    logic                     a_big;
    logic [4:0]               s;
    logic [15:0]              fe;
  } side_t;

  // (2^k)-th root of two in Q1.30: floor square root applied k times to 2.0
  function automatic logic [31:0] exp2_root(input int k);
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] acc;
    logic [63:0] b;
    r = 64'd1 << 31;
    for (int j = 0; j < k; j++) begin
      v   = r << 30;
      acc = '0;
      b   = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
        if (v >= acc + b) begin
          v   = v - (acc + b);
          acc = (acc >> 1) + b;
        end else begin
          acc = acc >> 1;
        end
        b = b >> 2;
      end
      r = acc;
    end
    return r[31:0];
  endfunction

endpackage

[src/cep_in_if.sv]
// cep_in_if: input channel of the crowding effect block
// valid/ready handshake with one opcode and its operands per beat; uses cep_pkg
interface cep_in_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [cep_pkg::SPECIES_W-1:0]    species;
  logic [cep_pkg::SEL_W-1:0]        coef_select;
  logic signed [cep_pkg::COEF_W-1:0] coef_value;
  logic [cep_pkg::DIAM_W-1:0]       diameter;
  logic [cep_pkg::NCI_W-1:0]        crowding_index;

  modport source (output valid, opcode, species, coef_select, coef_value, diameter,
                  crowding_index, input ready);
  modport sink (input valid, opcode, species, coef_select, coef_value, diameter,
                crowding_index, output ready);
endinterface

[src/cep_out_if.sv]
// cep_out_if: result channel of the crowding effect block
// valid/ready handshake, one crowding factor per beat; uses cep_pkg
interface cep_out_if;
  logic                         valid;
  logic                         ready;
  logic [cep_pkg::RES_W-1:0]    crowding_effect;
  logic                         saturated;

  modport source (output valid, crowding_effect, saturated, input ready);
  modport sink (input valid, crowding_effect, saturated, output ready);
endinterface

[src/cep_log2.sv]
// cep_log2: pipelined log2 of a 32-bit integer, one normalize stage then
// one squaring stage per fraction bit; uses cep_pkg
module cep_log2 (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] value,
  output logic [4:0]  msb,
  output logic [15:0] frac
);

  localparam int STEPS = cep_pkg::LOG_STEPS;

  logic [30:0] m_r    [0:STEPS];
  logic [4:0]  msb_r  [0:STEPS];
  logic [15:0] frac_r [0:STEPS];

  logic [4:0]  top;
  logic [61:0] wide;

  always_comb begin
    top = '0;
    for (int i = 0; i < 32; i++) begin
      if (value[i]) top = 5'(i);
    end
    wide = {value, 30'd0} >> top;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= wide[30:0];
      msb_r[0]  <= top;
      frac_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_sq
    logic [61:0] sq;
    assign sq = 62'(m_r[k-1]) * 62'(m_r[k-1]);

    // mantissa in Q1.30; a square at or above 2.0 yields a one bit
    always_ff @(posedge clk) begin
      if (en) begin
        msb_r[k]  <= msb_r[k-1];
        frac_r[k] <= {frac_r[k-1][14:0], sq[61]};
        if (sq[61]) begin
          m_r[k] <= sq[61:31];
        end else begin
          m_r[k] <= sq[60:30];
        end
      end
    end
  end

  assign msb  = msb_r[STEPS];
  assign frac = frac_r[STEPS];

endmodule

[src/cep_exp2.sv]
// cep_exp2: pipelined 2^f for a 16-bit fraction f, result in Q1.30
// one stage per fraction bit multiplies by a constant root of two; uses cep_pkg
module cep_exp2 (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] frac_in,
  output logic [31:0] pow
);

  localparam int STEPS = cep_pkg::EXP_STEPS;

  logic [31:0] m_r [0:STEPS-1];
  logic [15:0] f_r [0:STEPS-1];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [31:0] ROOT = cep_pkg::exp2_root(k + 1);
    logic [31:0] m_prev;
    logic [15:0] f_prev;
    logic [63:0] prod;

    if (k == 0) begin : g_first
      assign m_prev = cep_pkg::ONE_Q30;
      assign f_prev = frac_in;
    end else begin : g_next
      assign m_prev = m_r[k-1];
      assign f_prev = f_r[k-1];
    end

    assign prod = 64'(m_prev) * 64'(ROOT);

    always_ff @(posedge clk) begin
      if (en) begin
        f_r[k] <= f_prev;
        m_r[k] <= f_prev[STEPS-1-k] ? prod[61:30] : m_prev;
      end
    end
  end

  assign pow = m_r[STEPS-1];

endmodule

[src/crowding_effect_power_exp.sv]
// crowding_effect_power_exp: crowding factor exp(-C * diam^gamma * nci^D) in fixed point
// an accepted compute beat passes the 57-stage pipeline (17 log2 stages, two 16-stage
// exp2 runs) and the output register; one beat per cycle while the skid slot is free
// coefficient writes land in the tables at the accepting edge and yield no result beat
// rst_n (synchronous) clears valid bits only; coefficient tables are undefined until written
// uses cep_pkg, cep_in_if, cep_out_if, cep_log2, cep_exp2
module crowding_effect_power_exp #(
  parameter int NUM_SPECIES = cep_pkg::NUM_SPECIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  cep_in_if.sink        in_if,
  cep_out_if.source     out_if
);

  localparam int AW = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;

  localparam int ST_RD  = 1;   // table read
  localparam int ST_PRE = 2;   // coefficient select, normalize
  localparam int ST_LOG = 18;  // log2 done
  localparam int ST_MUL = 19;  // coefficient times log
  localparam int ST_CLS = 20;  // exponent sum and classification
  localparam int ST_X1  = 36;  // first exp2 done
  localparam int ST_T   = 37;
  localparam int ST_Z   = 38;
  localparam int ST_A   = 39;
  localparam int ST_E   = 40;
  localparam int ST_X2  = 56;  // second exp2 done
  localparam int N      = 57;  // rounding, last pipeline stage

  logic adv;
  logic acc_in;
  logic in_range;
  logic [AW-1:0] addr;

  logic [cep_pkg::COEF_W-1:0] slope_mem [0:NUM_SPECIES-1];
  logic [cep_pkg::COEF_W-1:0] steep_mem [0:NUM_SPECIES-1];
  logic [cep_pkg::COEF_W-1:0] gamma_mem [0:NUM_SPECIES-1];
  logic [cep_pkg::COEF_W-1:0] c_rd_r;
  logic [cep_pkg::COEF_W-1:0] d_rd_r;
  logic [cep_pkg::COEF_W-1:0] g_rd_r;

  logic [N:1]      v_r;
  cep_pkg::side_t  side_r   [1:N];
  cep_pkg::side_t  side_nxt [1:N];

  logic [4:0]  nci_msb;
  logic [4:0]  diam_msb;
  logic [15:0] nci_frac;
  logic [15:0] diam_frac;
  logic [31:0] x1_pow;
  logic [31:0] x2_pow;

  cep_pkg::res_t fin;
  cep_pkg::res_t out_r;
  cep_pkg::res_t sk_r;
  logic          out_v_r;
  logic          sk_v_r;

  // the pipeline moves whenever the skid slot is free
  assign adv         = !sk_v_r;
  assign in_if.ready = adv;
  assign acc_in      = in_if.valid && adv;
  assign addr        = AW'(in_if.species);
  assign in_range    = 32'(in_if.species) < 32'(NUM_SPECIES);

  always_ff @(posedge clk) begin
    if (acc_in && in_if.opcode == cep_pkg::OP_WRITE && in_range) begin
      unique case (in_if.coef_select)
        cep_pkg::SEL_SLOPE: slope_mem[addr] <= in_if.coef_value;
        cep_pkg::SEL_STEEP: steep_mem[addr] <= in_if.coef_value;
        cep_pkg::SEL_GAMMA: gamma_mem[addr] <= in_if.coef_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_rd_r <= slope_mem[addr];
      d_rd_r <= steep_mem[addr];
      g_rd_r <= gamma_mem[addr];
    end
  end

  cep_log2 u_log_nci (
    .clk   (clk),
    .en    (adv),
    .value (side_r[ST_RD].nci),
    .msb   (nci_msb),
    .frac  (nci_frac)
  );

  cep_log2 u_log_diam (
    .clk   (clk),
    .en    (adv),
    .value (32'(side_r[ST_RD].diam)),
    .msb   (diam_msb),
    .frac  (diam_frac)
  );

  cep_exp2 u_exp_pow (
    .clk     (clk),
    .en      (adv),
    .frac_in (side_r[ST_CLS].fp),
    .pow     (x1_pow)
  );

  cep_exp2 u_exp_res (
    .clk     (clk),
    .en      (adv),
    .frac_in (side_r[ST_E].fe),
    .pow     (x2_pow)
  );

  always_comb begin
    logic signed [21:0] lg_nci;
    logic signed [21:0] lg_diam;
    logic signed [46:0] acc;
    logic signed [47:0] accr;
    logic signed [31:0] lq;
    logic               ovf;
    logic [54:0]        tp;
    logic [5:0]         sh;
    logic [55:0]        zs;
    logic signed [21:0] e;
    logic signed [6:0]  sf;
    logic [32:0]        rs;

    side_nxt[ST_RD]          = '0;
    side_nxt[ST_RD].in_range = in_range;
    side_nxt[ST_RD].diam     = in_if.diameter;
    side_nxt[ST_RD].nci      = in_if.crowding_index;
    for (int i = 2; i <= N; i++) begin
      side_nxt[i] = side_r[i-1];
    end

    // out-of-range species reads all coefficients as zero
    side_nxt[ST_PRE].c = side_r[ST_RD].in_range ? $signed(c_rd_r) : '0;
    side_nxt[ST_PRE].d = side_r[ST_RD].in_range ? $signed(d_rd_r) : '0;
    side_nxt[ST_PRE].g = side_r[ST_RD].in_range ? $signed(g_rd_r) : '0;
    side_nxt[ST_PRE].diam_zero = side_r[ST_RD].diam == '0;
    side_nxt[ST_PRE].nci_zero  = side_r[ST_RD].nci == '0;

    // log2 nci less 16, log2 diam less 12, both Q.16
    lg_nci  = $signed({1'b0, nci_msb, nci_frac}) - 22'sd1048576;
    lg_diam = $signed({1'b0, diam_msb, diam_frac}) - 22'sd786432;
    side_nxt[ST_MUL].pd = side_r[ST_LOG].d * lg_nci;
    side_nxt[ST_MUL].pg = side_r[ST_LOG].g * lg_diam;

    acc  = 47'(side_r[ST_MUL].pd)
         + (side_r[ST_MUL].diam_zero ? 47'sd0 : 47'(side_r[ST_MUL].pg));
    accr = 48'(acc) + 48'sd32768;
    lq   = accr[47:16];
    ovf  = side_r[ST_MUL].diam_zero && side_r[ST_MUL].g < 24'sd0;
    side_nxt[ST_CLS].ip   = lq[31:16];
    side_nxt[ST_CLS].fp   = lq[15:0];
    side_nxt[ST_CLS].calc = 1'b0;
    side_nxt[ST_CLS].res  = cep_pkg::ONE_Q16;
    side_nxt[ST_CLS].sat  = 1'b0;
    if (side_r[ST_MUL].nci_zero || side_r[ST_MUL].c == 24'sd0) begin
      side_nxt[ST_CLS].calc = 1'b0;
    end else if (side_r[ST_MUL].diam_zero && side_r[ST_MUL].g > 24'sd0) begin
      side_nxt[ST_CLS].calc = 1'b0;
    end else if (ovf || lq >= 32'sd1572864) begin
      side_nxt[ST_CLS].sat = 1'b1;
      side_nxt[ST_CLS].res = (side_r[ST_MUL].c > 24'sd0) ? '0 : cep_pkg::ONE_Q16;
    end else if (side_r[ST_MUL].c < 24'sd0) begin
      side_nxt[ST_CLS].calc = 1'b0;
    end else begin
      side_nxt[ST_CLS].calc = 1'b1;
    end

    // c is positive on the computed path
    tp = 55'(side_r[ST_X1].c[22:0]) * 55'(x1_pow);
    side_nxt[ST_T].t = tp[54:30];

    side_nxt[ST_Z].z = 56'(side_r[ST_T].t) * 56'(cep_pkg::LOG2E_Q30);

    // shift by 30 - ip; past 55 bits nothing is left
    sh = 6'(16'sd30 - side_r[ST_Z].ip);
    if (side_r[ST_Z].ip < -16'sd25) begin
      zs = '0;
    end else begin
      zs = side_r[ST_Z].z >> sh;
    end
    side_nxt[ST_A].a     = zs[20:0];
    side_nxt[ST_A].a_big = zs >= 56'd1114112;

    e  = 22'sd1048576 - $signed({1'b0, side_r[ST_A].a});
    sf = 7'sd30 - 7'($signed(e[21:16]));
    side_nxt[ST_E].fe = e[15:0];
    side_nxt[ST_E].s  = sf[4:0];
    if (side_r[ST_A].calc && side_r[ST_A].a_big) begin
      side_nxt[ST_E].calc = 1'b0;
      side_nxt[ST_E].res  = '0;
    end

    rs = (33'(x2_pow) + (33'd1 << (side_r[ST_X2].s - 5'd1))) >> side_r[ST_X2].s;
    if (side_r[ST_X2].calc) begin
      side_nxt[N].res = (rs > 33'd65536) ? cep_pkg::ONE_Q16 : rs[16:0];
      side_nxt[N].sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= N; i++) begin
        side_r[i] <= side_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[N-1:1], acc_in && in_if.opcode == cep_pkg::OP_CALC};
    end
  end

  // output register with one skid slot behind it
  assign fin.res = side_r[N].res;
  assign fin.sat = side_r[N].sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (sk_v_r) begin
      if (out_if.ready) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end
    end else if (!out_v_r || out_if.ready) begin
      out_v_r <= v_r[N];
    end else if (v_r[N]) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (out_if.ready) out_r <= sk_r;
    end else if (!out_v_r || out_if.ready) begin
      out_r <= fin;
    end else begin
      sk_r <= fin;
    end
  end

  assign out_if.valid           = out_v_r;
  assign out_if.crowding_effect = out_r.res;
  assign out_if.saturated       = out_r.sat;

endmodule

[sim/crowding_effect_power_exp_tb.sv]
// crowding_effect_power_exp_tb: self-checking bench for the crowding effect block
// predicts each compute beat in fixed point and compares result beats in order
// depends on cep_pkg, cep_in_if, cep_out_if and crowding_effect_power_exp
module crowding_effect_power_exp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [cep_pkg::SPECIES_W-1:0] species_t;
  typedef logic [cep_pkg::SEL_W-1:0]     sel_t;
  typedef logic [cep_pkg::COEF_W-1:0]    coef_t;
  typedef logic [cep_pkg::DIAM_W-1:0]    diam_t;
  typedef logic [cep_pkg::NCI_W-1:0]     nci_t;

  localparam sel_t SEL_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;

  cep_in_if  in_bus ();
  cep_out_if out_bus ();

  crowding_effect_power_exp DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  logic signed [cep_pkg::COEF_W-1:0] slope_tab [cep_pkg::NUM_SPECIES_DEF];
  logic signed [cep_pkg::COEF_W-1:0] steep_tab [cep_pkg::NUM_SPECIES_DEF];
  logic signed [cep_pkg::COEF_W-1:0] gamma_tab [cep_pkg::NUM_SPECIES_DEF];

  cep_pkg::res_t effect_q[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   hold_req = 0;
  int   burst_left = 0;
  bit   gaps_on = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bit_v;
    root  = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= root + bit_v) begin
        v    = v - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root;
  endfunction

  function automatic longint log2_fix(logic [31:0] v);
    int msb;
    longint unsigned m;
    logic [15:0] frac;
    msb  = 0;
    frac = '0;
    for (int i = 0; i < 32; i++) if (v[i]) msb = i;
    m = (longint'(v) << 30) >> msb;
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        frac[k] = 1'b1;
        m = m >> 1;
      end
    end
    return (longint'(msb) << 16) | longint'(frac);
  endfunction

  function automatic longint unsigned exp2_fix(logic [15:0] f);
    longint unsigned m, r;
    m = 64'd1 << 30;
    r = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      r = int_sqrt(r << 30);
      if (f[16-k]) m = (m * r) >> 30;
    end
    return m;
  endfunction

  function automatic cep_pkg::res_t crowding_of(species_t sp, diam_t diam, nci_t nci);
    longint c, d, g, acc, lq, ip, sh, e, ie;
    longint unsigned mag, t, z, a, r, res;
    logic [15:0] fp, fe;
    bit ovf, zero_pow;
    int s;
    cep_pkg::res_t out;
    c = slope_tab[sp];
    d = steep_tab[sp];
    g = gamma_tab[sp];
    res = 65536;
    ovf = 0;
    out.sat = 1'b0;
    if (nci != 0 && c != 0) begin
      acc = d * (log2_fix(nci) - (64'sd16 << 16));
      zero_pow = 0;
      if (diam == 0) begin
        if (g < 0) ovf = 1;
        else if (g > 0) zero_pow = 1;
      end else begin
        acc = acc + g * (log2_fix({8'h00, diam}) - (64'sd12 << 16));
      end
      if (!ovf && !zero_pow) begin
        lq = (acc + 32768) >>> 16;
        if (lq >= (64'sd24 << 16)) begin
          ovf = 1;
        end else begin
          ip  = lq >>> 16;
          fp  = lq[15:0];
          mag = (c < 0) ? -c : c;
          t   = (mag * exp2_fix(fp)) >> 30;
          z   = t * longint'(cep_pkg::LOG2E_Q30);
          sh  = 30 - ip;
          a   = (sh >= 63) ? 0 : (z >> sh);
          if (c < 0) begin
            res = 65536;
          end else if (a >= (64'd17 << 16)) begin
            res = 0;
          end else begin
            e  = (64'sd16 << 16) - longint'(a);
            ie = e >>> 16;
            fe = e[15:0];
            s  = 30 - int'(ie);
            r  = exp2_fix(fe);
            res = (r + (64'd1 << (s - 1))) >> s;
            if (res > 65536) res = 65536;
          end
        end
      end
      if (ovf) begin
        out.sat = 1'b1;
        res = (c > 0) ? 0 : 65536;
      end
    end
    out.res = res[cep_pkg::RES_W-1:0];
    return out;
  endfunction

  // ---------------- sender ----------------
  task automatic send_beat(logic op, species_t sp, sel_t sel, coef_t val, diam_t diam,
                           nci_t nci);
    int gap;
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_bus.valid          = 1'b1;
    in_bus.opcode         = op;
    in_bus.species        = sp;
    in_bus.coef_select    = sel;
    in_bus.coef_value     = val;
    in_bus.diameter       = diam;
    in_bus.crowding_index = nci;
    do @(posedge clk); while (!in_bus.ready);
    if (op == cep_pkg::OP_WRITE) begin
      unique case (sel)
        cep_pkg::SEL_SLOPE: slope_tab[sp] = val;
        cep_pkg::SEL_STEEP: steep_tab[sp] = val;
        cep_pkg::SEL_GAMMA: gamma_tab[sp] = val;
        default: ;
      endcase
    end else begin
      effect_q.push_back(crowding_of(sp, diam, nci));
    end
  endtask

  task automatic write_coef(species_t sp, sel_t sel, coef_t val);
    send_beat(cep_pkg::OP_WRITE, sp, sel, val, diam_t'($urandom), nci_t'($urandom));
  endtask

  task automatic compute(species_t sp, diam_t diam, nci_t nci);
    send_beat(cep_pkg::OP_CALC, sp, sel_t'($urandom), coef_t'($urandom), diam, nci);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  // mostly moderate coefficients so results land inside (0,1)
  function automatic coef_t rand_coef(sel_t sel);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      if (sel == cep_pkg::SEL_SLOPE) return coef_t'($urandom_range(1, 1 << 16));
      return coef_t'($urandom_range(0, 1 << 17) - (1 << 16));
    end
    if (pick == 6) return 24'h800000;
    if (pick == 7) return 24'h7fffff;
    if (pick == 8) return 24'h000000;
    return coef_t'($urandom);
  endfunction

  function automatic diam_t rand_diam();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick < 6) return diam_t'($urandom_range(1 << 10, 1 << 16));
    return diam_t'($urandom);
  endfunction

  function automatic nci_t rand_nci();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick < 6) return nci_t'($urandom_range(1 << 12, 1 << 20));
    return nci_t'($urandom);
  endfunction

  // ---------------- receiver ----------------
  initial begin
    int phase;
    out_bus.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_req > 0) begin
        out_bus.ready = 1'b0;
        hold_req--;
      end else begin
        unique case ((phase / 97) % 4)
          0: out_bus.ready = 1'b1;
          1: out_bus.ready = ($urandom_range(0, 1) == 1);
          2: out_bus.ready = (phase % 5 != 0);
          default: out_bus.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ---------------- result checker and watchdog ----------------
  always @(posedge clk) begin
    cep_pkg::res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (effect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: effect=%0d sat=%0d",
                   out_bus.crowding_effect, out_bus.saturated);
      end else begin
        want = effect_q.pop_front();
        if (out_bus.crowding_effect !== want.res || out_bus.saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: effect exp=%0d got=%0d, sat exp=%0d got=%0d",
                     want.res, out_bus.crowding_effect, want.sat, out_bus.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic load_all_coefs();
    for (int sp = 0; sp < cep_pkg::NUM_SPECIES_DEF; sp++) begin
      write_coef(species_t'(sp), cep_pkg::SEL_SLOPE, rand_coef(cep_pkg::SEL_SLOPE));
      write_coef(species_t'(sp), cep_pkg::SEL_STEEP, rand_coef(cep_pkg::SEL_STEEP));
      write_coef(species_t'(sp), cep_pkg::SEL_GAMMA, rand_coef(cep_pkg::SEL_GAMMA));
    end
  endtask

  task automatic test_special_cases();
    write_coef(species_t'(0), cep_pkg::SEL_SLOPE, 24'h010000);
    write_coef(species_t'(0), cep_pkg::SEL_STEEP, 24'h010000);
    write_coef(species_t'(0), cep_pkg::SEL_GAMMA, 24'h010000);
    compute(species_t'(0), 24'h001000, 32'h0001_0000);
    compute(species_t'(0), 24'h001000, '0);
    compute(species_t'(0), '1, '1);
    compute(species_t'(0), '0, 32'h0002_0000);
    compute(species_t'(0), 24'h000001, 32'h0000_0001);
    // ignored select must leave the slope alone
    write_coef(species_t'(0), SEL_UNUSED, 24'h7fffff);
    compute(species_t'(0), 24'h002000, 32'h0003_0000);
    write_coef(species_t'(1), cep_pkg::SEL_SLOPE, '0);
    write_coef(species_t'(1), cep_pkg::SEL_STEEP, 24'h010000);
    write_coef(species_t'(1), cep_pkg::SEL_GAMMA, 24'hff0000);
    compute(species_t'(1), 24'h003000, 32'h0004_0000);
    write_coef(species_t'(1), cep_pkg::SEL_SLOPE, 24'h800000);
    compute(species_t'(1), '0, 32'h0001_0000);
    compute(species_t'(1), 24'h001000, 32'h0004_0000);
    write_coef(species_t'(1), cep_pkg::SEL_SLOPE, 24'h7fffff);
    compute(species_t'(1), '0, 32'h0001_0000);
    write_coef(species_t'(1), cep_pkg::SEL_GAMMA, '0);
    compute(species_t'(1), '0, 32'h0008_0000);
    write_coef(species_t'(1), cep_pkg::SEL_STEEP, 24'h7fffff);
    compute(species_t'(1), 24'h001000, '1);
    compute(species_t'(1), 24'h001000, 32'h0000_8000);
  endtask

  task automatic test_random(int count);
    sel_t sel;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        sel = sel_t'($urandom);
        write_coef(species_t'($urandom), sel, rand_coef(sel));
      end else begin
        compute(species_t'($urandom), rand_diam(), rand_nci());
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    gaps_on  = 0;
    for (int i = 0; i < 150; i++) compute(species_t'($urandom), rand_diam(), rand_nci());
    gaps_on  = 1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = cep_pkg::OP_CALC;
    in_bus.species = '0;
    in_bus.coef_select = cep_pkg::SEL_SLOPE;
    in_bus.coef_value = '0;
    in_bus.diameter = '0;
    in_bus.crowding_index = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    load_all_coefs();
    test_special_cases();
    test_random(100);
    test_backpressure();
    gaps_on = 0;
    test_random(50);
    gaps_on = 1;
    test_random(80);
    drop_valid();

    while (effect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && effect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
